// File: sv/xcrc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xcrc_pkg
// Shared types, codes and constants for the XMODEM-CRC packet receiver.
// ----------------------------------------------------------------------------
package xcrc_pkg;

	localparam int PAYLOAD_BYTES_DEF = 128;

	localparam logic [15:0] CRC_POLY = 16'h1021;

	localparam logic [7:0] CH_SOH = 8'h01;
	localparam logic [7:0] CH_EOT = 8'h04;
	localparam logic [7:0] CH_CAN = 8'h18;
	localparam logic [7:0] CH_Q   = 8'h71;

	typedef enum logic {
		ST_IDLE,
		ST_PACKET
	} rx_state_t;

	typedef enum logic {
		REPLY_ACK = 1'b0,
		REPLY_NAK = 1'b1
	} reply_t;

	typedef enum logic [1:0] {
		ERR_NONE    = 2'd0,
		ERR_TIMEOUT = 2'd1,
		ERR_COMPL   = 2'd2,
		ERR_CRC     = 2'd3
	} err_t;

	typedef enum logic [1:0] {
		TS_CONTINUE = 2'd0,
		TS_EOT      = 2'd1,
		TS_CAN      = 2'd2,
		TS_ABORT    = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       timed_out;
	} item_t;

	typedef struct packed {
		logic       reply_valid;
		logic       reply_code;
		logic       data_valid;
		logic [7:0] data_byte;
		logic       packet_end;
		logic       commit;
		logic [7:0] block_number;
		logic [1:0] error_kind;
		logic [1:0] transfer_status;
	} result_t;

endpackage
`default_nettype wire

// File: sv/xmodem_crc_packet_receiver.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xmodem_crc_packet_receiver
// XMODEM-CRC receiver: one received byte or timeout per beat, one result
// per beat with reply, streamed payload byte and packet verdict.
// ----------------------------------------------------------------------------
// Structure: two register stages, the input register and the result register,
// with decode and the byte-wide CRC update combinational between them.
// Throughput: one beat per cycle; while a result waits the input register takes
// one more beat, then the input stalls until the waiting result is accepted.
// Reset: arst_n clears both valid bits and all receiver state (idle, CRC 0,
// last accepted block 0).
module xmodem_crc_packet_receiver #(
	parameter int PAYLOAD_BYTES = xcrc_pkg::PAYLOAD_BYTES_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_stall,
	input  wire xcrc_pkg::item_t   item,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output xcrc_pkg::result_t      result
);

	logic              valid_s1;
	xcrc_pkg::item_t   item_s1;
	logic              valid_s2;
	xcrc_pkg::result_t result_s2;
	xcrc_pkg::result_t step_result;
	logic              s2_free;
	logic              advance;
	logic              accept;

	assign s2_free    = !valid_s2 || !result_stall;
	assign advance    = valid_s1 && s2_free;
	assign item_stall = valid_s1 && !s2_free;
	assign accept     = item_valid && !item_stall;

	xcrc_step #(
		.PAYLOAD_BYTES (PAYLOAD_BYTES)
	) u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (advance),
		.item   (item_s1),
		.result (step_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= advance;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= step_result;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

	a_stall_only_when_held: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1)
		else $error("input stalled with empty input register");

	a_commit_needs_ack: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.commit) |->
		(result.packet_end && result.reply_code == xcrc_pkg::REPLY_ACK))
		else $error("commit without an acknowledged packet end");

	a_error_matches_nak: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.packet_end) |->
		((result.error_kind != xcrc_pkg::ERR_NONE) ==
		 (result.reply_code == xcrc_pkg::REPLY_NAK)))
		else $error("packet end error kind disagrees with reply");

	a_data_not_end: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.data_valid && result.packet_end))
		else $error("payload byte on a packet end beat");

endmodule
`default_nettype wire

// File: sv/xcrc_crc_byte.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xcrc_crc_byte
// One-byte CRC-16 update, polynomial 0x1021, MSB first.
// ----------------------------------------------------------------------------
module xcrc_crc_byte (
	input  wire logic [15:0] crc_in,
	input  wire logic [7:0]  data,
	output logic      [15:0] crc_out
);

	always_comb begin
		logic [15:0] c;
		c = crc_in ^ {data, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ xcrc_pkg::CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		crc_out = c;
	end

endmodule
`default_nettype wire

// File: sv/xcrc_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xcrc_step
// Receiver state and per-beat decode: header handling, packet byte
// sequencing, CRC accumulation and the end-of-packet verdict.
// ----------------------------------------------------------------------------
module xcrc_step #(
	parameter int PAYLOAD_BYTES = xcrc_pkg::PAYLOAD_BYTES_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             take,
	input  wire xcrc_pkg::item_t  item,
	output xcrc_pkg::result_t     result
);

	localparam int POS_W = $clog2(PAYLOAD_BYTES + 4);
	localparam logic [POS_W-1:0] POS_BLOCK  = POS_W'(0);
	localparam logic [POS_W-1:0] POS_COMPL  = POS_W'(1);
	localparam logic [POS_W-1:0] POS_CRC_HI = POS_W'(PAYLOAD_BYTES + 2);
	localparam logic [POS_W-1:0] POS_LAST   = POS_W'(PAYLOAD_BYTES + 3);

	xcrc_pkg::rx_state_t state_q, state_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic [7:0]       block_q, block_d;
	logic [7:0]       compl_q, compl_d;
	logic [15:0]      crc_q, crc_d;
	logic [7:0]       crc_hi_q, crc_hi_d;
	logic [7:0]       last_block_q, last_block_d;
	logic [15:0]      crc_next;

	xcrc_crc_byte u_crc (
		.crc_in  (crc_q),
		.data    (item.rx_byte),
		.crc_out (crc_next)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			xcrc_pkg::ST_IDLE: begin
				if (!item.timed_out && item.rx_byte == xcrc_pkg::CH_SOH) begin
					state_d = xcrc_pkg::ST_PACKET;
				end
			end
			xcrc_pkg::ST_PACKET: begin
				if (item.timed_out || pos_q == POS_LAST) begin
					state_d = xcrc_pkg::ST_IDLE;
				end
			end
			default: state_d = xcrc_pkg::ST_IDLE;
		endcase
	end

	// result and datapath updates
	always_comb begin
		result       = '0;
		pos_d        = pos_q;
		block_d      = block_q;
		compl_d      = compl_q;
		crc_d        = crc_q;
		crc_hi_d     = crc_hi_q;
		last_block_d = last_block_q;
		case (state_q)
			xcrc_pkg::ST_IDLE: begin
				if (!item.timed_out) begin
					case (item.rx_byte)
						xcrc_pkg::CH_SOH: begin
							pos_d    = '0;
							block_d  = '0;
							compl_d  = '0;
							crc_d    = '0;
							crc_hi_d = '0;
						end
						xcrc_pkg::CH_EOT: begin
							result.reply_valid     = 1'b1;
							result.reply_code      = xcrc_pkg::REPLY_ACK;
							result.transfer_status = xcrc_pkg::TS_EOT;
							last_block_d           = '0;
						end
						xcrc_pkg::CH_CAN: begin
							result.reply_valid     = 1'b1;
							result.reply_code      = xcrc_pkg::REPLY_ACK;
							result.transfer_status = xcrc_pkg::TS_CAN;
							last_block_d           = '0;
						end
						xcrc_pkg::CH_Q: begin
							result.transfer_status = xcrc_pkg::TS_ABORT;
							last_block_d           = '0;
						end
						default: ;
					endcase
				end
			end
			xcrc_pkg::ST_PACKET: begin
				if (item.timed_out) begin
					result.reply_valid  = 1'b1;
					result.reply_code   = xcrc_pkg::REPLY_NAK;
					result.packet_end   = 1'b1;
					result.block_number = block_q;
					result.error_kind   = xcrc_pkg::ERR_TIMEOUT;
					pos_d               = '0;
				end else if (pos_q == POS_BLOCK) begin
					block_d = item.rx_byte;
					pos_d   = pos_q + POS_W'(1);
				end else if (pos_q == POS_COMPL) begin
					compl_d = item.rx_byte;
					pos_d   = pos_q + POS_W'(1);
				end else if (pos_q < POS_CRC_HI) begin
					crc_d            = crc_next;
					result.data_valid = 1'b1;
					result.data_byte  = item.rx_byte;
					pos_d            = pos_q + POS_W'(1);
				end else if (pos_q == POS_CRC_HI) begin
					crc_hi_d = item.rx_byte;
					pos_d    = pos_q + POS_W'(1);
				end else begin
					result.reply_valid  = 1'b1;
					result.packet_end   = 1'b1;
					result.block_number = block_q;
					pos_d               = '0;
					if ((block_q ^ compl_q) != 8'hFF) begin
						result.reply_code = xcrc_pkg::REPLY_NAK;
						result.error_kind = xcrc_pkg::ERR_COMPL;
					end else if ({crc_hi_q, item.rx_byte} != crc_q) begin
						result.reply_code = xcrc_pkg::REPLY_NAK;
						result.error_kind = xcrc_pkg::ERR_CRC;
					end else begin
						// suppress a repeated block
						result.reply_code = xcrc_pkg::REPLY_ACK;
						result.commit     = (block_q != last_block_q);
						last_block_d      = block_q;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= xcrc_pkg::ST_IDLE;
			pos_q        <= '0;
			block_q      <= '0;
			compl_q      <= '0;
			crc_q        <= '0;
			crc_hi_q     <= '0;
			last_block_q <= '0;
		end else if (take) begin
			state_q      <= state_d;
			pos_q        <= pos_d;
			block_q      <= block_d;
			compl_q      <= compl_d;
			crc_q        <= crc_d;
			crc_hi_q     <= crc_hi_d;
			last_block_q <= last_block_d;
		end
	end

endmodule
`default_nettype wire

// File: bench/xmodem_crc_packet_receiver_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xmodem_crc_packet_receiver_tb
// Self-checking bench for the XMODEM-CRC packet receiver. A queue of byte and
// timeout beats drives the input side under random gaps. A behavioral receiver
// model predicts one result per accepted beat. The monitor checks every result
// field against the oldest prediction while the result side stalls at random.
// ----------------------------------------------------------------------------
module xmodem_crc_packet_receiver_tb;

	localparam int PB         = xcrc_pkg::PAYLOAD_BYTES_DEF;
	localparam int ITEM_COUNT = 1350;
	localparam int LIMIT      = 100000;
	localparam int HOLD_LEN   = 80;
	localparam int HOLD_AT    = 600;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              item_valid   = 1'b0;
	logic              item_stall;
	xcrc_pkg::item_t   item         = '0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	xcrc_pkg::result_t result;

	xmodem_crc_packet_receiver i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	xcrc_pkg::item_t   pending_items[$];
	xcrc_pkg::result_t expected_results[$];
	int      cycle_count = 0;
	int      idle_pct;
	int      fail_count = 0;
	int      n_checked = 0;
	int      n_committed = 0;
	int      n_duplicates = 0;
	int      n_transfer_ends = 0;
	int      n_errors[4] = '{0, 0, 0, 0};
	logic [7:0] header_codes[4] = '{xcrc_pkg::CH_SOH, xcrc_pkg::CH_EOT,
		xcrc_pkg::CH_CAN, xcrc_pkg::CH_Q};

	// no idling on either side during a quiet window
	assign idle_pct = (cycle_count >= 1500 && cycle_count < 2500) ? 0 : 22;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT) begin
			$display("timeout after %0d cycles, %0d results still expected",
				cycle_count, expected_results.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// receiver model
	// ------------------------------------------------------------------
	xcrc_pkg::rx_state_t rcv_state = xcrc_pkg::ST_IDLE;
	logic [7:0] rcv_pos = '0;
	logic [7:0] rcv_block = '0;
	logic [7:0] rcv_compl = '0;
	logic [15:0] rcv_crc = '0;
	logic [7:0] rcv_crc_hi = '0;
	logic [7:0] rcv_last_block = '0;

	function automatic logic [15:0] crc16_update(logic [15:0] c, logic [7:0] b);
		logic [15:0] v;
		v = c ^ {b, 8'h00};
		for (int k = 0; k < 8; k++)
			v = v[15] ? ((v << 1) ^ xcrc_pkg::CRC_POLY) : (v << 1);
		return v;
	endfunction

	function automatic xcrc_pkg::result_t predict_reply(xcrc_pkg::item_t it);
		xcrc_pkg::result_t r;
		int unsigned pos;
		r = '0;
		if (rcv_state == xcrc_pkg::ST_IDLE) begin
			if (it.timed_out)
				return r;
			case (it.rx_byte)
			xcrc_pkg::CH_SOH: begin
				rcv_state = xcrc_pkg::ST_PACKET;
				rcv_pos = '0;
				rcv_block = '0;
				rcv_compl = '0;
				rcv_crc = '0;
				rcv_crc_hi = '0;
			end
			xcrc_pkg::CH_EOT: begin
				r.reply_valid = 1'b1;
				r.reply_code = xcrc_pkg::REPLY_ACK;
				r.transfer_status = xcrc_pkg::TS_EOT;
				rcv_last_block = '0;
			end
			xcrc_pkg::CH_CAN: begin
				r.reply_valid = 1'b1;
				r.reply_code = xcrc_pkg::REPLY_ACK;
				r.transfer_status = xcrc_pkg::TS_CAN;
				rcv_last_block = '0;
			end
			xcrc_pkg::CH_Q: begin
				r.transfer_status = xcrc_pkg::TS_ABORT;
				rcv_last_block = '0;
			end
			default: ;
			endcase
			return r;
		end
		if (it.timed_out) begin
			r.reply_valid = 1'b1;
			r.reply_code = xcrc_pkg::REPLY_NAK;
			r.packet_end = 1'b1;
			r.block_number = rcv_block;
			r.error_kind = xcrc_pkg::ERR_TIMEOUT;
			rcv_state = xcrc_pkg::ST_IDLE;
			rcv_pos = '0;
			return r;
		end
		pos = 32'(rcv_pos);
		if (pos == 0) begin
			rcv_block = it.rx_byte;
		end else if (pos == 1) begin
			rcv_compl = it.rx_byte;
		end else if (pos < PB + 2) begin
			rcv_crc = crc16_update(rcv_crc, it.rx_byte);
			r.data_valid = 1'b1;
			r.data_byte = it.rx_byte;
		end else if (pos == PB + 2) begin
			rcv_crc_hi = it.rx_byte;
		end else begin
			r.reply_valid = 1'b1;
			r.packet_end = 1'b1;
			r.block_number = rcv_block;
			if ((rcv_block ^ rcv_compl) != 8'hFF) begin
				r.reply_code = xcrc_pkg::REPLY_NAK;
				r.error_kind = xcrc_pkg::ERR_COMPL;
			end else if ({rcv_crc_hi, it.rx_byte} != rcv_crc) begin
				r.reply_code = xcrc_pkg::REPLY_NAK;
				r.error_kind = xcrc_pkg::ERR_CRC;
			end else begin
				r.reply_code = xcrc_pkg::REPLY_ACK;
				r.commit = (rcv_block != rcv_last_block);
				rcv_last_block = rcv_block;
			end
			rcv_state = xcrc_pkg::ST_IDLE;
			rcv_pos = '0;
			return r;
		end
		rcv_pos = 8'(pos + 1);
		return r;
	endfunction

	// ------------------------------------------------------------------
	// input driver
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
		end else begin
			if (item_valid && !item_stall)
				expected_results.push_back(predict_reply(item));
			if (!item_valid || !item_stall) begin
				if (pending_items.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
					item_valid <= 1'b1;
					item <= pending_items.pop_front();
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// long hold-off of the result side, so the block fills and stalls
	// ------------------------------------------------------------------
	int hold_left = 0;

	always @(posedge clk or negedge arst_n) begin : hold_counter
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (cycle_count == HOLD_AT) begin
			hold_left <= HOLD_LEN;
		end
	end

	// ------------------------------------------------------------------
	// result monitor
	// ------------------------------------------------------------------
	task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : result_monitor
		xcrc_pkg::result_t want;
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_results.size() == 0) begin
					$error("result beat with nothing expected");
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					n_checked++;
					check_field("reply_valid", 8'(want.reply_valid),
						8'(result.reply_valid));
					check_field("reply_code", 8'(want.reply_code),
						8'(result.reply_code));
					check_field("data_valid", 8'(want.data_valid),
						8'(result.data_valid));
					check_field("data_byte", want.data_byte, result.data_byte);
					check_field("packet_end", 8'(want.packet_end),
						8'(result.packet_end));
					check_field("commit", 8'(want.commit), 8'(result.commit));
					check_field("block_number", want.block_number, result.block_number);
					check_field("error_kind", 8'(want.error_kind),
						8'(result.error_kind));
					check_field("transfer_status", 8'(want.transfer_status),
						8'(result.transfer_status));
					if (want.packet_end) begin
						n_errors[want.error_kind]++;
						if (want.commit)
							n_committed++;
						else if (want.error_kind == xcrc_pkg::ERR_NONE)
							n_duplicates++;
					end
					if (want.transfer_status != xcrc_pkg::TS_CONTINUE)
						n_transfer_ends++;
				end
			end
			if (hold_left != 0) begin
				result_stall <= 1'b1;
			end else begin
				result_stall <= ($urandom_range(0, 99) < idle_pct);
			end
		end
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	int n_ignored = 0;

	task automatic push_item(logic [7:0] b, logic tmo);
		xcrc_pkg::item_t it;
		it.rx_byte = b;
		it.timed_out = tmo;
		pending_items.push_back(it);
	endtask

	// cut_at < 0 sends the whole packet, else a timeout replaces that byte
	task automatic send_packet(logic [7:0] blk, logic [7:0] cmpl, bit bad_crc, int cut_at);
		logic [15:0] crc;
		logic [7:0] d;
		crc = '0;
		push_item(xcrc_pkg::CH_SOH, 1'b0);
		for (int p = 0; p < PB + 4; p++) begin
			if (p == cut_at) begin
				push_item(8'($urandom), 1'b1);
				return;
			end
			if (p == 0) begin
				push_item(blk, 1'b0);
			end else if (p == 1) begin
				push_item(cmpl, 1'b0);
			end else if (p < PB + 2) begin
				d = ($urandom_range(0, 15) == 0) ? header_codes[2'($urandom_range(0, 3))]
					: 8'($urandom);
				crc = crc16_update(crc, d);
				push_item(d, 1'b0);
			end else if (p == PB + 2) begin
				push_item(crc[15:8], 1'b0);
			end else begin
				push_item(crc[7:0] ^ (bad_crc ? 8'($urandom_range(1, 255)) : 8'h00), 1'b0);
			end
		end
	endtask

	initial begin : stimulus
		logic [7:0] blk;
		logic [7:0] prev_good;
		logic [7:0] noise;
		int pick;

		// idle behavior and transfer ends
		push_item(8'hFF, 1'b1);
		push_item(8'h00, 1'b0);
		push_item(8'hFF, 1'b0);
		push_item(8'h55, 1'b0);
		push_item(xcrc_pkg::CH_EOT, 1'b0);
		push_item(xcrc_pkg::CH_CAN, 1'b0);
		push_item(xcrc_pkg::CH_Q, 1'b0);
		n_ignored += 4;
		// timeout before the block byte reports block 0
		push_item(xcrc_pkg::CH_SOH, 1'b0);
		push_item(8'h00, 1'b1);
		// header codes inside a packet are plain bytes
		push_item(xcrc_pkg::CH_SOH, 1'b0);
		push_item(xcrc_pkg::CH_EOT, 1'b0);
		push_item(xcrc_pkg::CH_CAN, 1'b0);
		push_item(8'hFF, 1'b0);
		push_item(8'hFF, 1'b1);
		push_item(xcrc_pkg::CH_SOH, 1'b0);
		push_item(xcrc_pkg::CH_SOH, 1'b0);
		push_item(8'h00, 1'b1);
		push_item(xcrc_pkg::CH_SOH, 1'b0);
		push_item(xcrc_pkg::CH_Q, 1'b0);
		push_item(8'h8E, 1'b0);
		push_item(8'h7F, 1'b1);

		// good packet, its duplicate, then one failing both checks
		send_packet(8'h01, 8'hFE, 1'b0, -1);
		send_packet(8'h01, 8'hFE, 1'b0, -1);
		send_packet(8'h02, 8'h02, 1'b1, -1);
		prev_good = 8'h01;

		while (pending_items.size() - n_ignored < ITEM_COUNT) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				case ($urandom_range(0, 5))
				0, 1:    blk = prev_good;
				2:       blk = 8'h00;
				3:       blk = 8'hFF;
				default: blk = 8'($urandom);
				endcase
				send_packet(blk, ~blk, 1'b0, -1);
				prev_good = blk;
			end else if (pick < 46) begin
				blk = 8'($urandom);
				send_packet(blk, ~blk ^ 8'($urandom_range(1, 255)), 1'b0, -1);
			end else if (pick < 52) begin
				blk = 8'($urandom);
				send_packet(blk, ~blk, 1'b1, -1);
			end else if (pick < 55) begin
				blk = 8'($urandom);
				send_packet(blk, blk, 1'b1, -1);
			end else if (pick < 72) begin
				blk = 8'($urandom);
				send_packet(blk, ~blk, 1'b0, ($urandom_range(0, 3) == 0) ?
					$urandom_range(0, PB + 3) : $urandom_range(0, 4));
			end else if (pick < 80) begin
				push_item(header_codes[2'($urandom_range(1, 3))], 1'b0);
			end else if (pick < 92) begin
				noise = 8'($urandom);
				if (noise == xcrc_pkg::CH_SOH || noise == xcrc_pkg::CH_EOT ||
					noise == xcrc_pkg::CH_CAN || noise == xcrc_pkg::CH_Q)
					noise = 8'hA5;
				push_item(noise, 1'b0);
				n_ignored++;
			end else begin
				push_item(8'($urandom), 1'b1);
				n_ignored++;
			end
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(negedge clk);
		while (pending_items.size() != 0 || item_valid || expected_results.size() != 0);
		repeat (10) @(posedge clk);

		$display("checked %0d result beats; packets: %0d committed, %0d duplicate, %0d timed out",
			n_checked, n_committed, n_duplicates, n_errors[xcrc_pkg::ERR_TIMEOUT]);
		$display("bad complement %0d, bad CRC %0d, transfer ends %0d",
			n_errors[xcrc_pkg::ERR_COMPL], n_errors[xcrc_pkg::ERR_CRC], n_transfer_ends);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
